FILE: rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants of the integer set table
// capacity, counter width, operation codes and the cell command beat
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // op code 3 is unused and acts as a membership test
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2
  } op_t;

  // command broadcast to every cell in the apply cycle
  typedef struct packed {
    logic               add_en;     // add of an absent value
    logic               remove_en;  // remove request
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  // what a cell reports to the rest of the row
  typedef struct packed {
    logic match;     // holds the value under test
    logic free_out;  // this cell or one before it is free
    logic occupied;
  } cell_stat_t;

endpackage

FILE: rtl/ist_cell.sv
// ----------------------------------------------------------------------------
// ist_cell: one entry of the set table
// holds a value and its valid bit, compares against the broadcast value and
// passes the free-slot claim along to its right-hand neighbour
// ----------------------------------------------------------------------------
module ist_cell (
  input  logic                clk,
  input  logic                rst,
  input  ist_pkg::cell_cmd_t  cmd,
  input  logic                free_in,
  output ist_pkg::cell_stat_t stat
);
  import ist_pkg::*;

  logic               valid;
  logic               valid_next;
  logic [VALUE_W-1:0] value;
  logic               claim;

  // first free cell in the row takes the new element
  assign claim = cmd.add_en && !valid && !free_in;

  always_comb begin
    valid_next = valid;
    if (claim) begin
      valid_next = 1'b1;
    end else if (cmd.remove_en && stat.match) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      value <= cmd.value;
    end
  end

  assign stat.match    = valid && (value == cmd.value);
  assign stat.free_out = free_in || !valid;
  assign stat.occupied = valid;

endmodule

FILE: rtl/integer_set_table.sv
// ----------------------------------------------------------------------------
// integer_set_table: fixed-capacity set of signed 32-bit integers
// add, remove and membership test on a row of compare-and-store cells
// ----------------------------------------------------------------------------
// usage
//   input beat: op and value are taken at a rising edge where start is high
//   and busy is low. op 0 adds, 1 removes, 2 (and the spare code 3) tests.
//   result beat: done is high for exactly one cycle with found, count,
//   is_empty and status; the receiver must take it then, it cannot stall
//   the block.
// timing
//   a beat is registered at acceptance, compared against all cells in the
//   following cycle and the cells are updated at the end of that cycle,
//   together with the result register. the cell row updates before the
//   next registered beat is compared, so one beat per cycle is sustained
//   while busy is low; the free-slot claim ripples through the row of cells
//   and sets the critical path of the apply cycle.
// reset
//   rst (synchronous, active high) empties the table and drops any beat in
//   flight; busy is high for the cycle that follows reset.
// notes
//   an add of a present value or to a full table changes nothing, the latter
//   reports status 1; a remove frees only the matching entry
// ----------------------------------------------------------------------------
module integer_set_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic signed [31:0] value,
  output logic        done,
  output logic        found,
  output logic [4:0]  count,
  output logic        is_empty,
  output logic        status
);
  import ist_pkg::*;

  // input stage
  logic               pend;
  logic [1:0]         pend_op;
  logic [VALUE_W-1:0] pend_value;

  // cell row
  cell_cmd_t              cmd;
  cell_stat_t [CAPACITY-1:0] stat;
  logic [CAPACITY-1:0]    match_vec;
  logic [CAPACITY-1:0]    occ_vec;
  logic                   hit_any;
  logic                   full;

  // element counter
  logic [COUNT_W-1:0] element_count;
  logic [COUNT_W-1:0] element_count_next;
  logic [31:0]        count_ext;
  logic               is_add;
  logic               is_remove;

  // busy is a registered copy of rst, so it is high in the cycle straight after reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pend_op    <= op;
      pend_value <= value;
    end
  end

  assign is_add    = pend && (pend_op == OP_ADD);
  assign is_remove = pend && (pend_op == OP_REMOVE);

  // match lines from every cell, or-reduced to a single hit
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = stat[i].match;
      occ_vec[i]   = stat[i].occupied;
    end
  end

  assign hit_any = |match_vec;
  assign full    = !stat[CAPACITY-1].free_out;

  assign cmd.add_en    = is_add && !hit_any;
  assign cmd.remove_en = is_remove;
  assign cmd.value     = pend_value;

  // row of cells, the free claim running from entry 0 upwards
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic free_in;
    if (g == 0) begin : g_first
      assign free_in = 1'b0;
    end else begin : g_rest
      assign free_in = stat[g-1].free_out;
    end
    ist_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .free_in (free_in),
      .stat    (stat[g])
    );
  end

  always_comb begin
    element_count_next = element_count;
    if (cmd.add_en && !full) begin
      element_count_next = element_count + COUNT_W'(1);
    end else if (is_remove && hit_any && (element_count != '0)) begin
      element_count_next = element_count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else begin
      element_count <= element_count_next;
    end
  end

  // result register
  assign count_ext = 32'(element_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      found    <= hit_any;
      count    <= count_ext[4:0];
      is_empty <= (element_count_next == '0);
      status   <= cmd.add_en && full;
    end
  end

  // every accepted beat yields exactly one result, through the pend and done registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    pend |=> done)
    else $error("pending beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !pend |=> !done)
    else $error("result without a pending beat");

  // counter tracks the number of occupied cells
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == 32'(element_count))
    else $error("element count differs from occupied cells");

  // at most one cell holds any value
  a_no_duplicates: assert property (@(posedge clk) disable iff (rst)
    pend |-> $onehot0(match_vec))
    else $error("value stored in more than one cell");

  // a dropped add only happens on a full table with an absent value
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (pend && cmd.add_en && full) |-> (32'(element_count) == CAPACITY))
    else $error("add dropped while table not full");

endmodule
